// ===== hdl/tile_map_row_blit_generator_unit_defines.svh =====
// Assertion macros shared by the tile-map blit generator RTL.
// Depends on nothing; include by bare file name.
`ifndef TILE_MAP_ROW_BLIT_GENERATOR_UNIT_DEFINES_SVH
`define TILE_MAP_ROW_BLIT_GENERATOR_UNIT_DEFINES_SVH
// implication checked on every clock outside reset
`define TMB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define TMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hdl/tmb_pkg.sv =====
// Shared types and codes for the tile-map row blit generator.
// No dependencies.
package tmb_pkg;
    typedef enum logic [1:0] {
        REQ_CELL  = 2'd0,
        REQ_SHEET = 2'd1,
        REQ_DRAW  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_MAP_COLUMNS = 2'd0,
        CFG_MAP_ROWS    = 2'd1,
        CFG_SCROLL_LEFT = 2'd2,
        CFG_SCROLL_TOP  = 2'd3
    } t_cfg;

    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CELL_W      = 20;
    localparam int unsigned SHEET_W     = 9;
    localparam logic [8:0]  MAX_SHEET   = 9'd256;
endpackage

// ===== hdl/tile_map_row_blit_generator_unit.sv =====
// Tile-map row blit generator: cell store, sheet width table, column sequencer.
// Depends on tmb_pkg and tile_map_row_blit_generator_unit_defines.svh.
//
// Use: raise start with a request while busy is low. Cell and sheet writes
// give no result. A draw request for a visible view row emits one blit
// word per visible column, left to right, each held on the o_ ports for
// one cycle under o_valid; o_last_in_row marks the last.
// A row first forms the map row product. Each column then walks: cell
// memory read (registered), sheet lookup, a restoring division of the tile
// number by the sheet width, one quotient bit a cycle, then the result word.
// Busy is set when the request is taken and stays high through the last
// column's emit state; the last word is on the ports in the cycle after that.
// The receiver cannot stall: each word is on the ports for exactly one cycle.
// Configuration (i_cfg_we/i_cfg_index/i_cfg_data) is taken any cycle and
// must be written while the block is idle.
// Reset (i_rst_n low, synchronous) clears the sheet table, registers to
// 64, 64, 0, 0 and the sequencer; the cell memory keeps undefined contents.
module tile_map_row_blit_generator_unit #(
    parameter int unsigned TILE_PIXELS = 16,
    parameter int unsigned VIEW_WIDTH  = 480,
    parameter int unsigned VIEW_HEIGHT = 272,
    parameter int unsigned MAP_CELLS   = 4096,
    parameter int unsigned SHEET_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [tmb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [11:0] i_target_index,
    input  logic [3:0]  i_sheet_slot,
    input  logic [15:0] i_tile_number,
    input  logic [8:0]  i_sheet_tiles_wide,
    output logic        o_valid,
    output logic        o_drawn,
    output logic [3:0]  o_out_sheet_slot,
    output logic [11:0] o_source_x,
    output logic [19:0] o_source_y,
    output logic [4:0]  o_blit_width,
    output logic [4:0]  o_blit_height,
    output logic [8:0]  o_dest_x,
    output logic [8:0]  o_dest_y,
    output logic        o_last_in_row
);
    import tmb_pkg::*;
    `include "tile_map_row_blit_generator_unit_defines.svh"

    localparam int unsigned TP_W   = $clog2(TILE_PIXELS);
    localparam int unsigned MA_W   = $clog2(MAP_CELLS);
    localparam int unsigned SL_W   = (SHEET_SLOTS > 1) ? $clog2(SHEET_SLOTS) : 1;
    localparam int unsigned MAXC   = (TILE_PIXELS - 1 + VIEW_WIDTH + TILE_PIXELS - 1)
                                     / TILE_PIXELS;
    localparam int unsigned COL_W  = $clog2(MAXC + 1);
    localparam int unsigned MAXR   = (TILE_PIXELS - 1 + VIEW_HEIGHT + TILE_PIXELS - 1)
                                     / TILE_PIXELS;

    typedef enum logic [2:0] {S_IDLE, S_ADDR, S_READ, S_LOOK, S_DIV, S_EMIT} t_state;

    // registers
    logic [12:0] r_cols, r_rows;
    logic [15:0] r_sl, r_st;
    logic [8:0]  r_sheet [SHEET_SLOTS];
    logic [CELL_W-1:0] r_mem [MAP_CELLS];
    logic [CELL_W-1:0] r_rd;

    t_state      r_state;
    logic [COL_W-1:0] r_j, r_ncols;
    logic [11:0] r_row;
    logic [16:0] r_mapy;           // scroll_top/TP + row
    logic [29:0] r_prod;           // map_y * cols
    logic        r_inmap;
    logic [3:0]  r_slot;
    logic [8:0]  r_w;
    logic        r_hit;
    logic [15:0] r_q;
    logic [8:0]  r_rem;
    logic [4:0]  r_bit;

    logic [TP_W-1:0] frac_x, frac_y;
    logic [16:0] map_x;
    logic [30:0] cidx;
    logic [9:0]  rem_sh;
    logic [31:0] row_start, row_hi, row_lo, col_start, col_hi, col_lo;
    logic [31:0] ncols_w, nrows_w;

    assign frac_x = r_sl[TP_W-1:0];
    assign frac_y = r_st[TP_W-1:0];
    assign ncols_w = (32'(frac_x) + VIEW_WIDTH + TILE_PIXELS - 1) >> TP_W;
    assign nrows_w = (32'(frac_y) + VIEW_HEIGHT + TILE_PIXELS - 1) >> TP_W;
    assign map_x = 17'(r_sl >> TP_W) + 17'(r_j);
    assign cidx  = 31'(map_x) + 31'(r_prod);
    assign rem_sh = {r_rem, r_q[15]};

    // clipping, by shifts and compares
    always_comb begin
        row_start = 32'(r_row) << TP_W;
        row_lo = (r_row == '0) ? 32'd0 : row_start - 32'(frac_y);
        row_hi = row_start + TILE_PIXELS - 32'(frac_y);
        if (row_hi > VIEW_HEIGHT) row_hi = VIEW_HEIGHT;
        if (row_lo > VIEW_HEIGHT) row_lo = VIEW_HEIGHT;
        col_start = 32'(r_j) << TP_W;
        col_lo = (r_j == '0) ? 32'd0 : col_start - 32'(frac_x);
        col_hi = col_start + TILE_PIXELS - 32'(frac_x);
        if (col_hi > VIEW_WIDTH) col_hi = VIEW_WIDTH;
        if (col_lo > VIEW_WIDTH) col_lo = VIEW_WIDTH;
    end

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= 13'd64;
            r_rows <= 13'd64;
            r_sl   <= '0;
            r_st   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg'(i_cfg_index))
                CFG_MAP_COLUMNS: r_cols <= i_cfg_data[12:0];
                CFG_MAP_ROWS:    r_rows <= i_cfg_data[12:0];
                CFG_SCROLL_LEFT: r_sl   <= i_cfg_data;
                CFG_SCROLL_TOP:  r_st   <= i_cfg_data;
            endcase
        end
    end

    // cell memory: one write port, one registered read
    always_ff @(posedge i_clk) begin
        if (start && !busy && t_req'(i_req_type) == REQ_CELL
            && 32'(i_target_index) < MAP_CELLS)
            r_mem[MA_W'(i_target_index)] <= {i_sheet_slot, i_tile_number};
        r_rd <= r_mem[MA_W'(cidx)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SHEET_SLOTS; i++) r_sheet[i] <= '0;
        end else if (start && !busy && t_req'(i_req_type) == REQ_SHEET
                     && 32'(i_target_index) < SHEET_SLOTS) begin
            r_sheet[SL_W'(i_target_index)] <=
                (i_sheet_tiles_wide > MAX_SHEET) ? MAX_SHEET : i_sheet_tiles_wide;
        end
    end

    // sequencer with registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (start && t_req'(i_req_type) == REQ_DRAW
                            && 32'(i_target_index) < nrows_w) begin
                    r_row   <= i_target_index;
                    r_ncols <= COL_W'(ncols_w);
                    r_j     <= '0;
                    r_mapy  <= 17'(r_st >> TP_W) + 17'(i_target_index);
                    r_state <= S_ADDR;
                end
                S_ADDR: begin
                    r_prod  <= 30'(r_mapy) * 30'(r_cols);
                    r_state <= S_READ;
                end
                S_READ: begin
                    // read address is formed from r_prod this cycle
                    r_inmap <= (32'(map_x) < 32'(r_cols)) && (32'(r_mapy) < 32'(r_rows))
                               && (32'(cidx) < MAP_CELLS);
                    r_state <= S_LOOK;
                end
                S_LOOK: begin
                    r_slot <= r_rd[19:16];
                    r_w    <= (32'(r_rd[19:16]) < SHEET_SLOTS) ?
                              r_sheet[SL_W'(r_rd[19:16])] : 9'd0;
                    r_hit  <= r_inmap && (32'(r_rd[19:16]) < SHEET_SLOTS)
                              && (r_sheet[SL_W'(r_rd[19:16])] != 9'd0);
                    r_q    <= r_rd[15:0];
                    r_rem  <= '0;
                    r_bit  <= 5'd16;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // restoring division, one quotient bit a cycle
                    if (r_bit == 5'd0) begin
                        r_state <= S_EMIT;
                    end else begin
                        if (r_w != 9'd0 && rem_sh >= {1'b0, r_w}) begin
                            r_rem <= 9'(rem_sh - {1'b0, r_w});
                            r_q   <= {r_q[14:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh[8:0];
                            r_q   <= {r_q[14:0], 1'b0};
                        end
                        r_bit <= r_bit - 5'd1;
                    end
                end
                S_EMIT: begin
                    o_valid          <= 1'b1;
                    o_drawn          <= r_hit;
                    o_out_sheet_slot <= r_hit ? r_slot : 4'd0;
                    o_source_x       <= r_hit ? 12'((32'(r_rem) << TP_W)
                                        + ((r_j == '0) ? 32'(frac_x) : 32'd0)) : 12'd0;
                    o_source_y       <= r_hit ? 20'((32'(r_q) << TP_W)
                                        + ((r_row == '0) ? 32'(frac_y) : 32'd0)) : 20'd0;
                    o_blit_width     <= 5'(col_hi - col_lo);
                    o_blit_height    <= 5'(row_hi - row_lo);
                    o_dest_x         <= 9'(col_lo);
                    o_dest_y         <= 9'(row_lo);
                    o_last_in_row    <= (r_j + 1'b1 == r_ncols);
                    if (r_j + 1'b1 == r_ncols) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_READ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `TMB_ASSERT_IMP(a_no_out_idle, i_clk, i_rst_n, o_valid && o_last_in_row, r_state == S_IDLE, "last word but still running")
    `TMB_ASSERT_IMP(a_drawn_slot, i_clk, i_rst_n, o_valid && !o_drawn, o_source_x == 12'd0 && o_source_y == 20'd0, "skipped cell with source")
    `TMB_ASSERT_NEXT(a_emit_out, i_clk, i_rst_n, r_state == S_EMIT, o_valid, "emit without word")
    `TMB_ASSERT_IMP(a_col_range, i_clk, i_rst_n, r_state != S_IDLE, 32'(r_ncols) <= MAXC && 32'(r_row) < MAXR, "column or row out of range")
endmodule

// ===== test/tile_map_row_blit_checker.sv =====
`timescale 1ns / 100ps
// Checker for the tile-map row blit generator: watches the request, config and
// result words, predicts blits per row and compares them. Depends on tmb_pkg.
module tile_map_row_blit_checker
    import tmb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_req_type,
    input  logic [11:0] i_target_index,
    input  logic [3:0]  i_sheet_slot,
    input  logic [15:0] i_tile_number,
    input  logic [8:0]  i_sheet_tiles_wide,
    input  logic        i_valid,
    input  logic        i_drawn,
    input  logic [3:0]  i_out_sheet_slot,
    input  logic [11:0] i_source_x,
    input  logic [19:0] i_source_y,
    input  logic [4:0]  i_blit_width,
    input  logic [4:0]  i_blit_height,
    input  logic [8:0]  i_dest_x,
    input  logic [8:0]  i_dest_y,
    input  logic        i_last_in_row,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_blit_count
);
    localparam int unsigned TILE = 16;
    localparam int unsigned VIEW_W = 480;
    localparam int unsigned VIEW_H = 272;
    localparam int unsigned CELLS = 4096;
    localparam int unsigned SLOTS = 16;

    typedef struct packed {
        logic        drawn;
        logic [3:0]  slot;
        logic [11:0] src_x;
        logic [19:0] src_y;
        logic [4:0]  wid;
        logic [4:0]  hgt;
        logic [8:0]  dst_x;
        logic [8:0]  dst_y;
        logic        last;
    } t_blit;

    logic [19:0] cell_mem [CELLS];
    logic [8:0]  sheet_tiles [SLOTS];
    logic [12:0] map_cols, map_rows;
    logic [15:0] scroll_x, scroll_y;
    t_blit       blit_queue [$];

    assign o_pending = blit_queue.size();

    // one axis of tile clipping against the view edge
    function automatic void clip(input int unsigned idx, input int unsigned frac,
                                 input int unsigned view, output int unsigned dst,
                                 output int unsigned size, output int unsigned off);
        int unsigned lo, hi;
        if (idx == 0) begin
            off = frac;
            lo = 0;
        end else begin
            off = 0;
            lo = idx * TILE - frac;
        end
        hi = idx * TILE + TILE - frac;
        if (hi > view) hi = view;
        if (lo > view) lo = view;
        dst = lo;
        size = hi - lo;
    endfunction

    task automatic predict_row(input int unsigned row);
        int unsigned fx, fy, ncols, nrows, ox, my, dy, hgt, offy;
        int unsigned mx, dx, wid, offx, cidx, w, tile;
        logic [3:0] cslot;
        t_blit b;
        fx = scroll_x % TILE;
        fy = scroll_y % TILE;
        ncols = (fx + VIEW_W + TILE - 1) / TILE;
        nrows = (fy + VIEW_H + TILE - 1) / TILE;
        if (row >= nrows) return;
        ox = scroll_x / TILE;
        my = scroll_y / TILE + row;
        clip(row, fy, VIEW_H, dy, hgt, offy);
        for (int unsigned j = 0; j < ncols; j++) begin
            mx = ox + j;
            clip(j, fx, VIEW_W, dx, wid, offx);
            b = '0;
            if (mx < map_cols && my < map_rows) begin
                cidx = mx + my * map_cols;
                if (cidx < CELLS) begin
                    cslot = cell_mem[cidx][19:16];
                    tile = cell_mem[cidx][15:0];
                    w = sheet_tiles[cslot];
                    if (w != 0) begin
                        b.drawn = 1'b1;
                        b.slot = cslot;
                        b.src_x = 12'((tile % w) * TILE + offx);
                        b.src_y = 20'((tile / w) * TILE + offy);
                    end
                end
            end
            b.wid = 5'(wid);
            b.hgt = 5'(hgt);
            b.dst_x = 9'(dx);
            b.dst_y = 9'(dy);
            b.last = (j + 1 == ncols);
            blit_queue.push_back(b);
        end
    endtask

    always @(posedge i_clk) begin
        t_blit got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) sheet_tiles[i] = '0;
            map_cols = 13'd64;
            map_rows = 13'd64;
            scroll_x = '0;
            scroll_y = '0;
            blit_queue.delete();
            o_fail_count = 0;
            o_blit_count = 0;
        end else begin
            if (i_valid) begin
                got = {i_drawn, i_out_sheet_slot, i_source_x, i_source_y, i_blit_width,
                       i_blit_height, i_dest_x, i_dest_y, i_last_in_row};
                o_blit_count++;
                if (blit_queue.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected blit word: %p", got);
                end else begin
                    want = blit_queue.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("blit mismatch\n  exp %p\n  got %p", want, got);
                    end
                end
            end
            if (i_cfg_we) begin
                unique case (t_cfg'(i_cfg_index))
                    CFG_MAP_COLUMNS: map_cols = i_cfg_data[12:0];
                    CFG_MAP_ROWS:    map_rows = i_cfg_data[12:0];
                    CFG_SCROLL_LEFT: scroll_x = i_cfg_data;
                    CFG_SCROLL_TOP:  scroll_y = i_cfg_data;
                endcase
            end
            if (i_start && !i_busy) begin
                case (t_req'(i_req_type))
                    REQ_CELL:  cell_mem[i_target_index] = {i_sheet_slot, i_tile_number};
                    REQ_SHEET:
                        if (i_target_index < SLOTS)
                            sheet_tiles[i_target_index] =
                                (i_sheet_tiles_wide > MAX_SHEET) ? MAX_SHEET : i_sheet_tiles_wide;
                    REQ_DRAW:  predict_row(i_target_index);
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== test/tb_tile_map_row_blit_generator_unit.sv =====
`timescale 1ns / 100ps
// Testbench top for the tile-map row blit generator: drives requests and
// config words, keeps cells written before any draw reads them. Needs tmb_pkg.
module tb_tile_map_row_blit_generator_unit;
    import tmb_pkg::*;

    localparam int LIMIT = 1500000;

    logic        i_clk = 1'b0, i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        start = 1'b0, busy;
    logic [1:0]  i_req_type = '0;
    logic [11:0] i_target_index = '0;
    logic [3:0]  i_sheet_slot = '0;
    logic [15:0] i_tile_number = '0;
    logic [8:0]  i_sheet_tiles_wide = '0;
    logic        o_valid, o_drawn, o_last_in_row;
    logic [3:0]  o_out_sheet_slot;
    logic [11:0] o_source_x;
    logic [19:0] o_source_y;
    logic [4:0]  o_blit_width, o_blit_height;
    logic [8:0]  o_dest_x, o_dest_y;
    int          fail_count, pending, blit_count;
    int          cycles = 0, words_sent = 0, draws_sent = 0;

    // driver-side copy of config and of which cells hold data
    int unsigned cols = 64, rows = 64, sx = 0, sy = 0;
    bit          cell_written [4096];

    tile_map_row_blit_generator_unit dut (.*);

    tile_map_row_blit_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_start(start), .i_busy(busy), .i_req_type, .i_target_index, .i_sheet_slot,
        .i_tile_number, .i_sheet_tiles_wide, .i_valid(o_valid), .i_drawn(o_drawn),
        .i_out_sheet_slot(o_out_sheet_slot), .i_source_x(o_source_x),
        .i_source_y(o_source_y), .i_blit_width(o_blit_width),
        .i_blit_height(o_blit_height), .i_dest_x(o_dest_x), .i_dest_y(o_dest_y),
        .i_last_in_row(o_last_in_row), .o_fail_count(fail_count), .o_pending(pending),
        .o_blit_count(blit_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // present one word, hold until accepted, then maybe idle
    task automatic send(input t_req req, input logic [11:0] tgt, input logic [3:0] slot,
                        input logic [15:0] tile, input logic [8:0] wide);
        int g;
        @(negedge i_clk);
        i_req_type <= req;
        i_target_index <= tgt;
        i_sheet_slot <= slot;
        i_tile_number <= tile;
        i_sheet_tiles_wide <= wide;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        words_sent++;
        if (req == REQ_CELL) cell_written[tgt] = 1'b1;
        if (req == REQ_DRAW) draws_sent++;
        g = gap_len();
        if (g > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    task automatic quiesce();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        do @(posedge i_clk); while (busy);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MAP_COLUMNS: cols = val[12:0];
            CFG_MAP_ROWS:    rows = val[12:0];
            CFG_SCROLL_LEFT: sx = val;
            CFG_SCROLL_TOP:  sy = val;
        endcase
    endtask

    task automatic set_view(input int unsigned c, input int unsigned r,
                            input int unsigned l, input int unsigned t);
        quiesce();
        write_reg(CFG_MAP_COLUMNS, 16'(c));
        write_reg(CFG_MAP_ROWS, 16'(r));
        write_reg(CFG_SCROLL_LEFT, 16'(l));
        write_reg(CFG_SCROLL_TOP, 16'(t));
    endtask

    // write every in-map cell the row will read that still holds nothing, then draw it
    task automatic draw_row(input logic [11:0] row);
        int unsigned ncols, nrows, mx, my, cidx;
        ncols = (sx % 16 + 495) / 16;
        nrows = (sy % 16 + 287) / 16;
        if (row < nrows) begin
            my = sy / 16 + row;
            for (int unsigned j = 0; j < ncols; j++) begin
                mx = sx / 16 + j;
                cidx = mx + my * cols;
                if (mx < cols && my < rows && cidx < 4096 && !cell_written[cidx])
                    send(REQ_CELL, 12'(cidx), 4'($urandom), 16'($urandom), 9'($urandom));
            end
        end
        send(REQ_DRAW, row, 4'($urandom), 16'($urandom), 9'($urandom));
    endtask

    function automatic int unsigned pick_dim();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 1;
        if (r == 1) return 4096;
        return $urandom_range(1, 40);
    endfunction

    function automatic int unsigned pick_scroll(input int unsigned dim);
        int unsigned hi;
        if ($urandom_range(0, 9) == 0) return 65535;
        hi = dim * 16 + 64;
        if (hi > 65535) hi = 65535;
        return $urandom_range(0, hi);
    endfunction

    initial begin
        int unsigned c, r, k;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: sheet widths incl. absent, one, max, saturated, bad slots
        send(REQ_SHEET, 12'd0, 4'd0, 16'd0, 9'd0);
        send(REQ_SHEET, 12'd1, 4'd0, 16'd0, 9'd1);
        send(REQ_SHEET, 12'd2, 4'd0, 16'd0, 9'd256);
        send(REQ_SHEET, 12'd3, 4'hf, 16'hffff, 9'h1ff);
        send(REQ_SHEET, 12'd15, 4'd0, 16'd0, 9'd7);
        send(REQ_SHEET, 12'd16, 4'd0, 16'd0, 9'd5);
        send(REQ_SHEET, 12'hfff, 4'hf, 16'hffff, 9'h1ff);
        send(REQ_NONE, 12'hfff, 4'hf, 16'hffff, 9'h1ff);
        send(REQ_CELL, 12'd0, 4'd0, 16'hffff, 9'd0);
        send(REQ_CELL, 12'd1, 4'd3, 16'hffff, 9'd0);
        send(REQ_CELL, 12'd2, 4'd1, 16'd0, 9'd0);
        draw_row(12'd0);
        draw_row(12'd16);
        draw_row(12'd17);
        draw_row(12'hfff);
        set_view(1, 1, 0, 0);
        draw_row(12'd0);
        set_view(4096, 4096, 65535, 65535);
        draw_row(12'd0);
        draw_row(12'd17);
        set_view(4096, 1, 15, 0);
        draw_row(12'd0);

        while (words_sent < 360) begin
            c = pick_dim();
            r = pick_dim();
            set_view(c, r, pick_scroll(c), pick_scroll(r));
            if ($urandom_range(0, 2) == 0)
                for (int s = 0; s < 16; s++)
                    send(REQ_SHEET, 12'(s), 4'($urandom), 16'($urandom),
                         9'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 12)));
            k = $urandom_range(4, 12);
            repeat (k) begin
                case ($urandom_range(0, 19))
                    0, 1, 2:
                        send(REQ_SHEET, 12'($urandom_range(0, 5) == 0 ? $urandom : $urandom % 16),
                             4'($urandom), 16'($urandom), 9'($urandom));
                    3, 4:
                        send(REQ_CELL, 12'($urandom), 4'($urandom), 16'($urandom),
                             9'($urandom));
                    5:
                        send(REQ_NONE, 12'($urandom), 4'($urandom), 16'($urandom),
                             9'($urandom));
                    6:
                        draw_row(12'($urandom));
                    default:
                        draw_row(12'($urandom_range(0, 17)));
                endcase
            end
        end

        quiesce();
        repeat (100) @(posedge i_clk);
        $display("covered %0d request words, %0d draw rows, %0d blit words checked",
                 words_sent, draws_sent, blit_count);
        $display("views swept map sizes 1..4096 and scrolls 0..65535");
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
